### rtl/ple_pkg.sv
package ple_pkg;

  localparam logic [1:0] ModeLoad   = 2'd0;
  localparam logic [1:0] ModeLocal  = 2'd1;
  localparam logic [1:0] ModeGlobal = 2'd2;

  localparam logic [1:0] CfgPathLength   = 2'd0;
  localparam logic [1:0] CfgSearchWindow = 2'd1;

  localparam logic [6:0] SearchWindowReset = 7'd50;

  // 0.5*pi in Q2.30
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] speed;
    logic signed [15:0] steering;
    logic [5:0]         points_wanted;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_heading;
    logic signed [15:0] out_speed;
    logic signed [15:0] out_steering;
    logic               last;
  } out_t;

  // one path store entry
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] heading;
    logic signed [15:0] speed;
    logic signed [15:0] steering;
  } wp_t;

  // quarter-wave sine entry k of 2^bits, Q15, odd Taylor series to x^15 in Q30
  function automatic logic [15:0] sine_entry(int unsigned k, int unsigned bits);
    longint unsigned x;
    longint unsigned t;
    longint unsigned v;
    longint          s;
    x = (HalfPiQ30 * longint'(k)) >> bits;
    t = x;
    s = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      case (n)
        1:       t = t / 6;
        2:       t = t / 20;
        3:       t = t / 42;
        4:       t = t / 72;
        5:       t = t / 110;
        6:       t = t / 156;
        default: t = t / 210;
      endcase
      if (n % 2 == 1) s = s - longint'(t);
      else            s = s + longint'(t);
    end
    if (s < 0) s = 0;
    v = (longint'(s) + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return v[15:0];
  endfunction

  // round half up from Q15 and saturate to 32 bits
  function automatic logic signed [31:0] scale_sat(logic signed [50:0] v);
    logic signed [51:0] r1;
    logic signed [36:0] r;
    r1 = 52'(v) + 52'sd16384;
    r  = 37'(r1 >>> 15);
    if (r > 37'sd2147483647)       return 32'sh7FFFFFFF;
    else if (r < -37'sd2147483648) return 32'sh80000000;
    else                           return r[31:0];
  endfunction

endpackage

### rtl/ple_ram.sv
module ple_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ple_trig.sv
// Registered sine of a binary angle from a quarter-wave table, Q1.15.
module ple_trig #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic [15:0]        angle_i,
  output logic signed [16:0] sin_o
);

  localparam int B      = SINE_TABLE_BITS;
  localparam int RomLen = (1 << B) + 1;

  logic [15:0]        rom [RomLen];
  logic [B-1:0]       fine;
  logic [B:0]         idx;
  logic [16:0]        mag;
  logic signed [16:0] sin_d;
  logic signed [16:0] sin_q;

  for (genvar k = 0; k < RomLen; k++) begin : g_rom
    assign rom[k] = ple_pkg::sine_entry(k, B);
  end

  always_comb begin
    fine = angle_i[13 -: B];
    idx  = angle_i[14] ? ({1'b1, {B{1'b0}}} - {1'b0, fine}) : {1'b0, fine};
    mag  = {1'b0, rom[idx]};
    sin_d = angle_i[15] ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
  end

  assign sin_o = sin_q;

endmodule

### rtl/path_lookahead_extractor.sv
// Path lookahead extractor. Load waypoints with mode 0 (one cycle each, busy
// stays low, no results). A local (1) or global (2) query raises busy and
// answers with points_wanted+1 items on out_valid_o, one cycle each, the
// receiver cannot stall them; out_o.last marks the final one. Query timing is
// set by the single-port read of the path store and the shared multiply stage:
// sine and cosine lookup and setup; read, difference, multiply and compare
// per scanned waypoint, with a final read to close the scan; the ego point;
// read, difference, multiply and output per emitted waypoint; then padding.
// busy drops on the cycle the final item is shown; the next start is taken
// then. Mode 3 is dropped. The store has no reset: read only written slots.
module path_lookahead_extractor #(
  parameter int PATH_DEPTH      = 1024,
  parameter int MAX_POINTS      = 63,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ple_pkg::in_t     item_i,
  output logic             out_valid_o,
  output ple_pkg::out_t    out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [10:0]      cfg_data_i
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int LW = $clog2(PATH_DEPTH + 1);
  localparam int WW = $bits(ple_pkg::wp_t);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StTrigS   = 4'd1;
  localparam logic [3:0] StTrigC   = 4'd2;
  localparam logic [3:0] StSetup   = 4'd3;
  localparam logic [3:0] StScanRd  = 4'd4;
  localparam logic [3:0] StScanDx  = 4'd5;
  localparam logic [3:0] StScanMul = 4'd6;
  localparam logic [3:0] StScanCmp = 4'd7;
  localparam logic [3:0] StEgo     = 4'd8;
  localparam logic [3:0] StEmitRd  = 4'd9;
  localparam logic [3:0] StEmitDx  = 4'd10;
  localparam logic [3:0] StEmitMul = 4'd11;
  localparam logic [3:0] StEmitOut = 4'd12;
  localparam logic [3:0] StPad     = 4'd13;

  // control
  logic [3:0]    state_q, state_d;
  logic [10:0]   plen_q;
  logic [6:0]    win_q;
  logic [LW-1:0] near_q, near_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] end_q, end_d;
  logic [LW-1:0] len_q, len_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          found_q, found_d;
  logic          strobe_q, strobe_d;

  // payload
  ple_pkg::in_t  req_q;
  ple_pkg::wp_t  wp_q;
  ple_pkg::out_t out_q, out_d;
  ple_pkg::out_t hold_q;
  logic [5:0]    n_q;
  logic [63:0]   best_q;
  logic signed [16:0] sin_q, cos_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [49:0] pa_q, pb_q, pc_q, pd_q;
  logic [63:0]   sqx_q, sqy_q;

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  ple_pkg::wp_t  ram_wdata;
  logic [WW-1:0] ram_rdata;
  ple_pkg::wp_t  rd_wp;
  logic [15:0]   trig_angle;
  logic signed [16:0] trig_sin;

  logic [LW:0]        sum_end;
  logic signed [50:0] proj;
  logic [64:0]        dsum;
  logic [63:0]        dist_sq;
  logic               better;
  logic [31:0]        ax, ay;
  logic [5:0]         n_clamp;
  logic               last_pt;

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = strobe_q;
  assign out_o       = out_q;
  assign rd_wp       = ram_rdata;

  // write a waypoint in the accept cycle; slots beyond the store are dropped
  assign ram_we = accept && (item_i.mode == ple_pkg::ModeLoad)
                  && (32'(item_i.slot) < 32'(PATH_DEPTH));
  assign ram_wdata = '{x: item_i.pos_x, y: item_i.pos_y, heading: item_i.heading,
                       speed: item_i.speed, steering: item_i.steering};
  assign ram_raddr = idx_q[AW-1:0];

  ple_ram #(
    .WIDTH(WW),
    .DEPTH(PATH_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(item_i.slot)),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sine first, cosine in the next cycle as sin(a + quarter turn)
  assign trig_angle = (state_q == StTrigC) ? (req_q.heading + 16'sd16384) : req_q.heading;

  ple_trig #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_trig (
    .clk_i  (clk_i),
    .angle_i(trig_angle),
    .sin_o  (trig_sin)
  );

  always_comb begin
    n_clamp = (32'(item_i.points_wanted) > 32'(MAX_POINTS)) ? 6'(MAX_POINTS)
                                                            : item_i.points_wanted;
    sum_end = {1'b0, near_q} + (LW + 1)'(win_q);
    proj    = 51'(pa_q) + 51'(pb_q);
    dsum    = {1'b0, sqx_q} + {1'b0, sqy_q};
    dist_sq = dsum[64] ? '1 : dsum[63:0];
    better  = (proj > 51'sd0) && (!found_q || dist_sq < best_q);
    ax      = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
    ay      = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
    last_pt = ((cnt_q + 6'd1) == n_q);
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    near_d   = near_q;
    idx_d    = idx_q;
    end_d    = end_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    strobe_d = 1'b0;
    out_d    = out_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (item_i.mode == ple_pkg::ModeLocal
                       || item_i.mode == ple_pkg::ModeGlobal)) begin
          state_d = StTrigS;
        end
      end
      StTrigS: state_d = StTrigC;
      StTrigC: state_d = StSetup;
      StSetup: begin
        // clamp path length to the store, clamp scan end to the path
        len_d   = (32'(plen_q) > 32'(PATH_DEPTH)) ? LW'(PATH_DEPTH) : LW'(plen_q);
        end_d   = (sum_end > (LW + 1)'(len_d)) ? len_d : LW'(sum_end);
        idx_d   = near_q;
        found_d = 1'b0;
        state_d = StScanRd;
      end
      StScanRd: state_d = (idx_q < end_q) ? StScanDx : StEgo;
      StScanDx: state_d = StScanMul;
      StScanMul: state_d = StScanCmp;
      StScanCmp: begin
        if (better) begin
          found_d = 1'b1;
          near_d  = idx_q;
        end
        idx_d   = idx_q + LW'(1);
        state_d = StScanRd;
      end
      StEgo: begin
        if (req_q.mode == ple_pkg::ModeLocal) begin
          out_d = '0;
        end else begin
          out_d = '{out_x: req_q.pos_x, out_y: req_q.pos_y, out_heading: req_q.heading,
                    out_speed: 16'sd0, out_steering: 16'sd0, last: 1'b0};
        end
        out_d.last = (n_q == 6'd0);
        strobe_d   = 1'b1;
        idx_d      = near_q;
        cnt_d      = 6'd0;
        state_d    = (n_q == 6'd0) ? StIdle : StEmitRd;
      end
      StEmitRd: state_d = (idx_q < len_q) ? StEmitDx : StPad;
      StEmitDx: state_d = StEmitMul;
      StEmitMul: state_d = StEmitOut;
      StEmitOut: begin
        if (req_q.mode == ple_pkg::ModeLocal) begin
          out_d.out_x       = ple_pkg::scale_sat(51'(pa_q) + 51'(pb_q));
          out_d.out_y       = ple_pkg::scale_sat(51'(pc_q) - 51'(pd_q));
          out_d.out_heading = wp_q.heading - req_q.heading;
        end else begin
          out_d.out_x       = wp_q.x;
          out_d.out_y       = wp_q.y;
          out_d.out_heading = wp_q.heading;
        end
        out_d.out_speed    = wp_q.speed;
        out_d.out_steering = wp_q.steering;
        out_d.last         = last_pt;
        strobe_d = 1'b1;
        idx_d    = idx_q + LW'(1);
        cnt_d    = cnt_q + 6'd1;
        state_d  = last_pt ? StIdle : StEmitRd;
      end
      StPad: begin
        // repeat the last shown point
        out_d      = hold_q;
        out_d.last = last_pt;
        strobe_d   = 1'b1;
        cnt_d      = cnt_q + 6'd1;
        state_d    = last_pt ? StIdle : StPad;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      plen_q   <= '0;
      win_q    <= ple_pkg::SearchWindowReset;
      near_q   <= '0;
      idx_q    <= '0;
      end_q    <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      near_q   <= near_d;
      idx_q    <= idx_d;
      end_q    <= end_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ple_pkg::CfgPathLength:   plen_q <= cfg_data_i;
          ple_pkg::CfgSearchWindow: win_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (strobe_d) begin
      hold_q <= out_d;
    end
    if (accept) begin
      req_q <= item_i;
      n_q   <= n_clamp;
    end
    if (state_q == StTrigC) begin
      sin_q <= trig_sin;
    end
    if (state_q == StSetup) begin
      cos_q <= trig_sin;
    end
    if (state_q == StScanDx || state_q == StEmitDx) begin
      wp_q <= rd_wp;
      dx_q <= 33'(rd_wp.x) - 33'(req_q.pos_x);
      dy_q <= 33'(rd_wp.y) - 33'(req_q.pos_y);
    end
    if (state_q == StScanMul || state_q == StEmitMul) begin
      pa_q  <= dx_q * cos_q;
      pb_q  <= dy_q * sin_q;
      pc_q  <= dy_q * cos_q;
      pd_q  <= dx_q * sin_q;
      sqx_q <= 64'(ax) * 64'(ax);
      sqy_q <= 64'(ay) * 64'(ay);
    end
    if (state_q == StScanCmp && better) begin
      best_q <= dist_sq;
    end
  end

endmodule

### verif/path_lookahead_checker.sv
module path_lookahead_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  ple_pkg::in_t  item_i,
  input  logic          out_valid_o,
  input  ple_pkg::out_t out_o,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [10:0]   cfg_data_i,
  output int            fail_count_o,
  output int            pending_o
);
  import ple_pkg::*;

  localparam int unsigned Depth    = 1024;
  localparam int unsigned MaxPts   = 63;
  localparam int unsigned RomBits  = 10;
  localparam int unsigned RomLen   = (1 << RomBits) + 1;

  int    sine_rom [RomLen];
  wp_t   path_mem [Depth];
  int unsigned nearest_idx;
  int unsigned path_len;
  int unsigned window_len;
  out_t  expected_pts [$];

  // quarter-wave table, odd series to x^15 in Q30
  initial begin
    longint unsigned x, t, v;
    longint          s;
    for (int k = 0; k < RomLen; k++) begin
      x = (64'd1686629713 * longint'(k)) >> RomBits;
      t = x;
      s = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - longint'(t);
        else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      v = (longint'(s) + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      sine_rom[k] = int'(v);
    end
  end

  function automatic int sine_q15(logic [15:0] a);
    int unsigned i;
    int m;
    i = 32'(a[13:0]) >> (14 - RomBits);
    if (a[14]) i = (1 << RomBits) - i;
    m = sine_rom[i];
    return a[15] ? -m : m;
  endfunction

  function automatic logic signed [31:0] round_sat(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (r < -64'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  task automatic predict_query(in_t it);
    longint vx, vy, dx, dy;
    longint unsigned ax, ay, d2x, d2y, dist_sq, best;
    int c, s;
    int unsigned len, stop, n, k;
    bit found;
    out_t pt;
    vx = it.pos_x;
    vy = it.pos_y;
    c = sine_q15(it.heading + 16'd16384);
    s = sine_q15(it.heading);
    len = (path_len > Depth) ? Depth : path_len;
    stop = nearest_idx + window_len;
    if (stop > len) stop = len;
    found = 0;
    best = 0;
    // scan ahead for the nearest waypoint with positive projection
    for (int unsigned i = nearest_idx; i < stop; i++) begin
      dx = longint'(path_mem[i].x) - vx;
      dy = longint'(path_mem[i].y) - vy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      d2x = ax * ax;
      d2y = ay * ay;
      dist_sq = d2x + d2y;
      if (dist_sq < d2x) dist_sq = '1;
      if (dx * c + dy * s > 0 && (!found || dist_sq < best)) begin
        found = 1;
        best = dist_sq;
        nearest_idx = i;
      end
    end
    n = it.points_wanted;
    if (n > MaxPts) n = MaxPts;
    pt = '0;
    if (it.mode == ModeGlobal) begin
      pt.out_x = it.pos_x;
      pt.out_y = it.pos_y;
      pt.out_heading = it.heading;
    end
    pt.last = (n == 0);
    expected_pts.push_back(pt);
    k = 1;
    for (int unsigned i = nearest_idx; i < nearest_idx + n && i < len; i++) begin
      if (it.mode == ModeLocal) begin
        dx = longint'(path_mem[i].x) - vx;
        dy = longint'(path_mem[i].y) - vy;
        pt.out_x = round_sat(dx * c + dy * s);
        pt.out_y = round_sat(dy * c - dx * s);
        pt.out_heading = path_mem[i].heading - it.heading;
      end else begin
        pt.out_x = path_mem[i].x;
        pt.out_y = path_mem[i].y;
        pt.out_heading = path_mem[i].heading;
      end
      pt.out_speed = path_mem[i].speed;
      pt.out_steering = path_mem[i].steering;
      pt.last = (k == n);
      expected_pts.push_back(pt);
      k++;
    end
    // pad by repeating the last point
    while (k < n + 1) begin
      pt.last = (k == n);
      expected_pts.push_back(pt);
      k++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      nearest_idx = 0;
      path_len = 0;
      window_len = SearchWindowReset;
      expected_pts.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_o) begin
        if (expected_pts.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected point %h", $time, out_o);
        end else begin
          want = expected_pts.pop_front();
          if (out_o.out_x !== want.out_x || out_o.out_y !== want.out_y ||
              out_o.out_heading !== want.out_heading ||
              out_o.out_speed !== want.out_speed ||
              out_o.out_steering !== want.out_steering || out_o.last !== want.last) begin
            fail_count_o++;
            $display("%0t: point mismatch expected x=%0d y=%0d h=%0d sp=%0d st=%0d l=%0b",
                     $time, want.out_x, want.out_y, want.out_heading, want.out_speed,
                     want.out_steering, want.last,
                     " actual x=%0d y=%0d h=%0d sp=%0d st=%0d l=%0b",
                     out_o.out_x, out_o.out_y, out_o.out_heading, out_o.out_speed,
                     out_o.out_steering, out_o.last);
          end
        end
      end
      if (start && !busy) begin
        if (item_i.mode == ModeLoad) begin
          path_mem[item_i.slot] = '{item_i.pos_x, item_i.pos_y, item_i.heading,
                                    item_i.speed, item_i.steering};
        end else if (item_i.mode == ModeLocal || item_i.mode == ModeGlobal) begin
          predict_query(item_i);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgPathLength) path_len = cfg_data_i;
        else if (cfg_index_i == CfgSearchWindow) window_len = cfg_data_i[6:0];
      end
    end
    pending_o = expected_pts.size();
  end

endmodule

### verif/path_lookahead_extractor_tb.sv
module path_lookahead_extractor_tb;
  import ple_pkg::*;

  // mode code the block drops
  localparam logic [1:0] ModeIgnored = 2'd3;
  // one waypoint every 2 m along x
  localparam int         WpStep      = 131072;
  // waypoints loaded at the start; every read stays below this
  localparam int         NumWp       = 32;
  localparam int         CycleLimit  = 1000000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_t         item_i;
  logic        out_valid_o;
  out_t        out_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [10:0] cfg_data_i;
  int          fail_count;
  int          pending_pts;
  int          cycles = 0;
  int          idle_pct;
  int          path_cursor;

  path_lookahead_extractor u_top (
    .clk_i, .rst_ni, .start, .busy, .item_i, .out_valid_o, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  path_lookahead_checker u_chk (
    .clk_i, .rst_ni, .start, .busy, .item_i, .out_valid_o, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending_pts)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // bail out on a hung handshake
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // call at a falling edge; hold start high until the block takes the item,
  // return at the next falling edge with start still high
  task automatic send_item(in_t it);
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop start for a random gap, per the phase's idle rate
  task automatic pace();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk_i);
    end
  endtask

  // drop start, wait for every point, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (pending_pts != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // waypoint near the line y = 0, heading roughly along +x
  function automatic in_t make_waypoint(int slot);
    in_t it;
    it = '0;
    it.mode = ModeLoad;
    it.slot = 10'(slot);
    it.pos_x = slot * WpStep + $signed($urandom_range(40000)) - 20000;
    it.pos_y = $signed($urandom_range(131072)) - 65536;
    it.heading = 16'($signed($urandom_range(4000)) - 2000);
    it.speed = 16'($urandom);
    it.steering = 16'($urandom);
    it.points_wanted = 6'($urandom);
    return it;
  endfunction

  // vehicle pose just behind a waypoint a little past the cursor
  function automatic in_t make_query(logic [1:0] mode, int tgt, logic [5:0] pts);
    in_t it;
    it = '0;
    it.mode = mode;
    it.slot = 10'($urandom);
    it.pos_x = tgt * WpStep - $signed($urandom_range(100000));
    it.pos_y = $signed($urandom_range(200000)) - 100000;
    it.heading = 16'($signed($urandom_range(6000)) - 3000);
    it.speed = 16'($urandom);
    it.steering = 16'($urandom);
    it.points_wanted = pts;
    return it;
  endfunction

  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 6'd63;
    if (r < 20) return 6'($urandom);
    return 6'($urandom_range(9));
  endfunction

  task automatic random_items(int count);
    in_t it;
    int r;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        it = make_waypoint($urandom_range(NumWp - 1));
      end else if (r < 15) begin
        it = make_query(ModeIgnored, path_cursor, 6'($urandom));
      end else if (r < 22) begin
        // noise pose: full-range fields
        it = make_query($urandom_range(1) ? ModeLocal : ModeGlobal, 0, pick_count());
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.heading = 16'($urandom);
      end else begin
        if (path_cursor < NumWp) path_cursor += $urandom_range(4);
        it = make_query($urandom_range(1) ? ModeLocal : ModeGlobal,
                        path_cursor + $urandom_range(3), pick_count());
      end
      send_item(it);
      pace();
    end
  endtask

  initial begin
    in_t it;
    idle_pct = 0;
    path_cursor = 8;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgPathLength;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty path: the ego point is all that can be padded
    it = make_query(ModeLocal, 0, 6'd0);
    send_item(it);
    it = make_query(ModeGlobal, 0, 6'd63);
    it.pos_x = 32'sh7FFFFFFF;
    it.pos_y = 32'sh80000000;
    it.heading = 16'sh7FFF;
    send_item(it);
    it.mode = ModeIgnored;
    send_item(it);

    // fill the start of the store; extremes near the path start
    for (int sl = 0; sl < NumWp; sl++) begin
      it = make_waypoint(sl);
      if (sl == 2) begin
        it.pos_x = 32'sh7FFFFFFF;
        it.pos_y = 32'sh7FFFFFFF;
        it.heading = 16'sh7FFF;
        it.speed = 16'sh7FFF;
        it.steering = 16'sh8000;
      end else if (sl == 3) begin
        it.pos_x = 32'sh80000000;
        it.pos_y = 32'sh80000000;
        it.heading = 16'sh8000;
        it.speed = 16'sh8000;
        it.steering = 16'sh7FFF;
      end
      send_item(it);
    end
    write_reg(CfgPathLength, 11'(NumWp));

    // saturating local points, then the global copy of the same run
    it = make_query(ModeLocal, 0, 6'd8);
    it.pos_x = -32'sd655360;
    it.heading = 16'sd0;
    send_item(it);
    it.mode = ModeGlobal;
    send_item(it);
    // sideways and backward headings
    it = make_query(ModeLocal, 1, 6'd5);
    it.heading = 16'sd16384;
    send_item(it);
    it.heading = 16'sh8000;
    it.points_wanted = 6'd63;
    send_item(it);
    // far corner pose facing -x: squared distances overflow
    it = make_query(ModeGlobal, 0, 6'd63);
    it.pos_x = 32'sh7FFFFFFF;
    it.pos_y = 32'sd0;
    it.heading = 16'sh8000;
    send_item(it);

    // full-rate phase, window of 64
    write_reg(CfgSearchWindow, 11'd64);
    random_items(20);

    idle_pct = 71;
    write_reg(CfgSearchWindow, 11'd1);
    random_items(20);

    // cut the path below the kept index, then restore it
    write_reg(CfgPathLength, 11'd5);
    for (int j = 0; j < 4; j++) begin
      send_item(make_query(j[0] ? ModeLocal : ModeGlobal, path_cursor, pick_count()));
      pace();
    end
    write_reg(CfgPathLength, 11'(NumWp));

    idle_pct = 34;
    write_reg(CfgSearchWindow, 11'd0);
    random_items(15);

    idle_pct = 0;
    write_reg(CfgSearchWindow, 11'd50);
    random_items(20);

    drain();
    if (fail_count == 0 && pending_pts == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
